@@ sv/kclc_pkg.sv @@
// shared types and constants of the keypad code lock controller
package kclc_pkg;

    // phase codes
    localparam logic [2:0] PH_ADMIN   = 3'd0;
    localparam logic [2:0] PH_NEWCODE = 3'd1;
    localparam logic [2:0] PH_USER    = 3'd2;
    localparam logic [2:0] PH_OPEN    = 3'd3;
    localparam logic [2:0] PH_CLOSE   = 3'd4;
    localparam logic [2:0] PH_LOCK    = 3'd5;

    // event codes
    localparam logic [2:0] EV_NONE       = 3'd0;
    localparam logic [2:0] EV_KEY        = 3'd1;
    localparam logic [2:0] EV_ADMIN_OK   = 3'd2;
    localparam logic [2:0] EV_ADMIN_FAIL = 3'd3;
    localparam logic [2:0] EV_SET        = 3'd4;
    localparam logic [2:0] EV_MATCH      = 3'd5;
    localparam logic [2:0] EV_MISMATCH   = 3'd6;
    localparam logic [2:0] EV_CLOSED     = 3'd7;

    // input item actions
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_ADMIN_CODE  = 2'd0;
    localparam logic [1:0] REG_OPEN_TICKS  = 2'd1;
    localparam logic [1:0] REG_CLOSE_TICKS = 2'd2;

    // configuration reset values
    localparam logic [31:0] ADMIN_CODE_RST  = 32'h3132_3334;
    localparam logic [15:0] OPEN_TICKS_RST  = 16'd600;
    localparam logic [15:0] CLOSE_TICKS_RST = 16'd600;

    // input item
    typedef struct packed {
        logic       action;
        logic [7:0] scan_code;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [2:0] phase;
        logic       motor_forward;
        logic       motor_reverse;
        logic [2:0] event_code;
        logic [7:0] key_char;
    } out_item_t;

    // decoded key
    typedef struct packed {
        logic       hit;
        logic [7:0] char_code;
    } key_t;

endpackage

@@ sv/kclc_key_decode.sv @@
// keypad row/column scan code to key character decoder
module kclc_key_decode
    import kclc_pkg::*;
(
    input  logic [7:0] scan_code,
    output key_t       key
);

    // fixed 4x4 keypad map, star key gives value 0
    always_comb begin
        key.hit       = 1'b1;
        key.char_code = 8'h00;
        case (scan_code)
            8'hEB: key.char_code = "1";
            8'hDB: key.char_code = "2";
            8'hBB: key.char_code = "3";
            8'h7B: key.char_code = "C";
            8'hED: key.char_code = "4";
            8'hDD: key.char_code = "5";
            8'hBD: key.char_code = "6";
            8'h7D: key.char_code = "B";
            8'hEE: key.char_code = "7";
            8'hDE: key.char_code = "8";
            8'hBE: key.char_code = "9";
            8'h7E: key.char_code = "A";
            8'hE7: key.char_code = 8'h00;
            8'hD7: key.char_code = "0";
            8'hB7: key.char_code = "#";
            8'h77: key.char_code = "D";
            default: key.hit = 1'b0;
        endcase
    end

endmodule

@@ sv/kclc_core.sv @@
// lock state, code buffers, motion timer and per-item next-state logic
module kclc_core
    import kclc_pkg::*;
#(
    parameter int CODE_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  in_item_t    item,
    input  logic [31:0] admin_code,
    input  logic [15:0] open_ticks,
    input  logic [15:0] close_ticks,
    output out_item_t   result
);

    localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_DIGITS - 1);

    logic [2:0]       phase_reg, phase_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [15:0]      timer_reg, timer_next;
    logic [7:0]       entry_reg [CODE_DIGITS];
    logic [7:0]       entry_next [CODE_DIGITS];
    logic [7:0]       user_reg [CODE_DIGITS];
    logic [7:0]       user_next [CODE_DIGITS];

    key_t                     key;
    logic [8*CODE_DIGITS-1:0] admin_ext;
    logic                     admin_ok;
    logic                     user_ok;
    logic [2:0]               event_code;
    logic [7:0]               key_char;

    kclc_key_decode u_key_decode (
        .scan_code (item.scan_code),
        .key       (key)
    );

    // buffers with the current key written in
    always_comb begin
        entry_next = entry_reg;
        user_next  = user_reg;
        if (item.action == ACT_KEY && key.hit) begin
            if (phase_reg == PH_NEWCODE) begin
                user_next[count_reg] = key.char_code;
            end else if (phase_reg == PH_ADMIN || phase_reg == PH_USER) begin
                entry_next[count_reg] = key.char_code;
            end
        end
    end

    // group compares, first key against the top byte
    assign admin_ext = (8*CODE_DIGITS)'(admin_code);

    always_comb begin
        admin_ok = 1'b1;
        user_ok  = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (entry_next[i] != admin_ext[8*(CODE_DIGITS-1-i) +: 8]) begin
                admin_ok = 1'b0;
            end
            if (entry_next[i] != user_next[i]) begin
                user_ok = 1'b0;
            end
        end
    end

    // phase, count and timer update for one item
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        timer_next = timer_reg;
        event_code = EV_NONE;
        key_char   = 8'h00;
        if (item.action == ACT_TICK) begin
            if (phase_reg == PH_OPEN) begin
                if (timer_reg <= 16'd1) begin
                    phase_next = PH_CLOSE;
                    timer_next = close_ticks;
                end else begin
                    timer_next = timer_reg - 16'd1;
                end
            end else if (phase_reg == PH_CLOSE) begin
                if (timer_reg <= 16'd1) begin
                    phase_next = PH_USER;
                    timer_next = 16'd0;
                    event_code = EV_CLOSED;
                end else begin
                    timer_next = timer_reg - 16'd1;
                end
            end
        end else if ((phase_reg == PH_ADMIN || phase_reg == PH_NEWCODE ||
                      phase_reg == PH_USER) && key.hit) begin
            key_char   = key.char_code;
            event_code = EV_KEY;
            if (count_reg == LAST_IDX) begin
                count_next = '0;
                case (phase_reg)
                    PH_ADMIN: begin
                        phase_next = admin_ok ? PH_NEWCODE : PH_LOCK;
                        event_code = admin_ok ? EV_ADMIN_OK : EV_ADMIN_FAIL;
                    end
                    PH_NEWCODE: begin
                        phase_next = PH_USER;
                        event_code = EV_SET;
                    end
                    default: begin
                        if (user_ok) begin
                            phase_next = PH_OPEN;
                            timer_next = open_ticks;
                            event_code = EV_MATCH;
                        end else begin
                            event_code = EV_MISMATCH;
                        end
                    end
                endcase
            end else begin
                count_next = count_reg + IDX_W'(1);
            end
        end
    end

    // result of this item
    always_comb begin
        result.phase         = phase_next;
        result.motor_forward = (phase_next == PH_OPEN);
        result.motor_reverse = (phase_next == PH_CLOSE);
        result.event_code    = event_code;
        result.key_char      = key_char;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_ADMIN;
            count_reg <= '0;
            timer_reg <= 16'd0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            timer_reg <= timer_next;
        end
    end

    // code buffers, no reset
    always_ff @(posedge aclk) begin
        if (step_en) begin
            entry_reg <= entry_next;
            user_reg  <= user_next;
        end
    end

endmodule

@@ sv/keypad_code_lock_controller.sv @@
// top level of the keypad code lock controller: handshake, item registers, config
//
// usage:
//   s_item carries one keypad scan code (action 0) or one time tick (action 1);
//   it is taken when s_valid and s_ready are both high.
//   every item gives exactly one result item on m_item, handed over when m_valid
//   and m_ready are both high: new phase, motor drive bits, event and key char.
//   admin_code, open_ticks and close_ticks are written through cfg_wr_en,
//   cfg_index and cfg_wdata; write them only while idle.
// timing:
//   the input register takes the item at the accepting edge; the phase/compare/timer
//   logic then loads the result register once that register is free, and m_valid
//   goes high with it, so the result is taken from the result register.
//   throughput is one item per cycle while m_ready stays high.
// reset:
//   aresetn low clears both registers' valid bits, puts the lock in admin entry
//   with an empty key count and loads the configuration reset values.
// stall:
//   while m_ready is low the result register holds, the input register fills,
//   and s_ready drops until the result is taken; nothing is lost or repeated.
module keypad_code_lock_controller
    import kclc_pkg::*;
#(
    parameter int CODE_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] admin_code_reg;
    logic [15:0] open_ticks_reg;
    logic [15:0] close_ticks_reg;
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;
    out_item_t   result;
    logic        step_en;

    // item moves from the input register to the result register
    assign step_en = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step_en;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    kclc_core #(
        .CODE_DIGITS (CODE_DIGITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .item        (in_item_reg),
        .admin_code  (admin_code_reg),
        .open_ticks  (open_ticks_reg),
        .close_ticks (close_ticks_reg),
        .result      (result)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            admin_code_reg  <= ADMIN_CODE_RST;
            open_ticks_reg  <= OPEN_TICKS_RST;
            close_ticks_reg <= CLOSE_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ADMIN_CODE:  admin_code_reg  <= cfg_wdata;
                REG_OPEN_TICKS:  open_ticks_reg  <= cfg_wdata[15:0];
                REG_CLOSE_TICKS: close_ticks_reg <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // valid bits of the input and result registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (step_en) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // item payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (step_en) begin
            out_item_reg <= result;
        end
    end

endmodule

@@ tb/keypad_code_lock_controller_test.sv @@
// self-checking testbench of the keypad code lock controller
module keypad_code_lock_controller_test;
    import kclc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CODE_LEN = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // the sixteen keypad scan codes, index 0 in the low byte
    localparam logic [16*8-1:0] KEY_SCANS = {
        8'h77, 8'hB7, 8'hD7, 8'hE7, 8'h7E, 8'hBE, 8'hDE, 8'hEE,
        8'h7D, 8'hBD, 8'hDD, 8'hED, 8'h7B, 8'hBB, 8'hDB, 8'hEB
    };

    // one row of the directed stimulus, with an optional typed-in result
    typedef struct packed {
        logic      action;
        logic [7:0] scan;
        logic      typed;
        out_item_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_item = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_item;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // shadow of the lock state and its registers
    logic [2:0]  lk_phase = PH_ADMIN;
    int          lk_count = 0;
    logic [7:0]  lk_entry [CODE_LEN];
    logic [7:0]  lk_user [CODE_LEN];
    logic [15:0] lk_timer = '0;
    logic [31:0] cfg_admin = ADMIN_CODE_RST;
    logic [15:0] cfg_open = OPEN_TICKS_RST;
    logic [15:0] cfg_close = CLOSE_TICKS_RST;
    int          close_count = 0;

    out_item_t   lock_results_due [$];
    in_item_t    key_plan [$];
    stim_row_t   dir_rows [24];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_request = 1'b0;
    int          hold_left = 0;
    int          fail_count = 0;
    int          cycle_count = 0;

    keypad_code_lock_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("keypad_code_lock_controller regression: fail");
            $finish;
        end
    end

    // keypad row/column decode
    function automatic key_t decode_scan(logic [7:0] code);
        key_t k;
        k.hit = 1'b1;
        case (code)
            8'hEB: k.char_code = 8'h31;
            8'hDB: k.char_code = 8'h32;
            8'hBB: k.char_code = 8'h33;
            8'h7B: k.char_code = 8'h43;
            8'hED: k.char_code = 8'h34;
            8'hDD: k.char_code = 8'h35;
            8'hBD: k.char_code = 8'h36;
            8'h7D: k.char_code = 8'h42;
            8'hEE: k.char_code = 8'h37;
            8'hDE: k.char_code = 8'h38;
            8'hBE: k.char_code = 8'h39;
            8'h7E: k.char_code = 8'h41;
            8'hE7: k.char_code = 8'h00;
            8'hD7: k.char_code = 8'h30;
            8'hB7: k.char_code = 8'h23;
            8'h77: k.char_code = 8'h44;
            default: begin
                k.hit = 1'b0;
                k.char_code = 8'h00;
            end
        endcase
        return k;
    endfunction

    // scan code that decodes to a given character
    function automatic logic [7:0] scan_for_char(logic [7:0] ch);
        logic [7:0] sc;
        sc = 8'h00;
        for (int i = 0; i < 16; i++) begin
            if (decode_scan(KEY_SCANS[8*i +: 8]).char_code == ch)
                sc = KEY_SCANS[8*i +: 8];
        end
        return sc;
    endfunction

    // next lock state and the result item of one accepted item
    function automatic out_item_t predict_lock_result(in_item_t it);
        out_item_t  r;
        key_t       k;
        logic [2:0] ev;
        logic [7:0] kc;
        int         idx;
        bit         same;
        ev = EV_NONE;
        kc = 8'h00;
        if (it.action == ACT_TICK) begin
            // ticks only count down the motion timers
            if (lk_phase == PH_OPEN) begin
                if (lk_timer <= 16'd1) begin
                    lk_phase = PH_CLOSE;
                    lk_timer = cfg_close;
                end else begin
                    lk_timer = lk_timer - 16'd1;
                end
            end else if (lk_phase == PH_CLOSE) begin
                if (lk_timer <= 16'd1) begin
                    lk_phase = PH_USER;
                    lk_timer = '0;
                    ev = EV_CLOSED;
                    close_count++;
                end else begin
                    lk_timer = lk_timer - 16'd1;
                end
            end
        end else if (lk_phase <= PH_USER) begin
            k = decode_scan(it.scan_code);
            if (k.hit) begin
                idx = (lk_count >= CODE_LEN) ? 0 : lk_count;
                kc = k.char_code;
                ev = EV_KEY;
                if (lk_phase == PH_NEWCODE)
                    lk_user[idx] = k.char_code;
                else
                    lk_entry[idx] = k.char_code;
                idx++;
                if (idx >= CODE_LEN) begin
                    // final key of a group decides the group
                    lk_count = 0;
                    if (lk_phase == PH_ADMIN) begin
                        if ({lk_entry[0], lk_entry[1], lk_entry[2], lk_entry[3]} == cfg_admin) begin
                            lk_phase = PH_NEWCODE;
                            ev = EV_ADMIN_OK;
                        end else begin
                            lk_phase = PH_LOCK;
                            ev = EV_ADMIN_FAIL;
                        end
                    end else if (lk_phase == PH_NEWCODE) begin
                        lk_phase = PH_USER;
                        ev = EV_SET;
                    end else begin
                        same = 1'b1;
                        for (int i = 0; i < CODE_LEN; i++)
                            if (lk_entry[i] != lk_user[i])
                                same = 1'b0;
                        if (same) begin
                            lk_phase = PH_OPEN;
                            lk_timer = cfg_open;
                            ev = EV_MATCH;
                        end else begin
                            ev = EV_MISMATCH;
                        end
                    end
                end else begin
                    lk_count = idx;
                end
            end
        end
        r.phase = lk_phase;
        r.motor_forward = (lk_phase == PH_OPEN);
        r.motor_reverse = (lk_phase == PH_CLOSE);
        r.event_code = ev;
        r.key_char = kc;
        return r;
    endfunction

    // random item: mostly whole code groups, some noise
    function automatic in_item_t next_stim_item();
        in_item_t it;
        int       r;
        it.action = ACT_KEY;
        it.scan_code = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (lk_phase == PH_OPEN || lk_phase == PH_CLOSE) begin
            // motion: ticks with the odd ignored key
            if (r < 90)
                it.action = ACT_TICK;
            else if (r < 95)
                it.scan_code = KEY_SCANS[8*$urandom_range(0, 15) +: 8];
            return it;
        end
        if (r < 4) begin
            it.action = 1'($urandom_range(0, 1));
            return it;
        end
        if (key_plan.size() == 0) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                for (int i = 0; i < CODE_LEN; i++)
                    key_plan.push_back(in_item_t'{ACT_KEY, scan_for_char(lk_user[i])});
            end else if (r < 85) begin
                for (int i = 0; i < CODE_LEN; i++)
                    key_plan.push_back(in_item_t'{ACT_KEY, KEY_SCANS[8*$urandom_range(0, 15) +: 8]});
            end else begin
                key_plan.push_back(in_item_t'{1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
            end
        end
        return key_plan.pop_front();
    endfunction

    // offer one item, wait for it to be taken, then queue its expected result
    task automatic send_item(in_item_t it, logic typed, out_item_t typed_want);
        out_item_t want;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item <= it;
        s_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_ready);
        want = predict_lock_result(it);
        lock_results_due.push_back(typed ? typed_want : want);
    endtask

    // one register write; the caller lowers the write enable after the last
    task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_ADMIN_CODE:  cfg_admin = data;
            REG_OPEN_TICKS:  cfg_open = data[15:0];
            REG_CLOSE_TICKS: cfg_close = data[15:0];
            default: ;
        endcase
    endtask

    // wait until every expected result is back and the pipeline is quiet
    task automatic drain();
        while (lock_results_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // random items until the budget is spent, the door is shut and a motion has closed
    task automatic run_phase(int budget, int s_idle, int r_idle);
        int n;
        int c0;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        n = 0;
        c0 = close_count;
        while (n < budget || lk_phase != PH_USER || close_count == c0) begin
            send_item(next_stim_item(), 1'b0, '0);
            n++;
        end
        s_valid <= 1'b0;
        drain();
    endtask

    // writes the admin code and both tick registers plus the unused index, then lowers the enable
    task automatic set_lock_regs(logic [31:0] admin, logic [15:0] open_t, logic [15:0] close_t);
        cfg_write(REG_ADMIN_CODE, admin);
        cfg_write(REG_OPEN_TICKS, {16'($urandom_range(0, 65535)), open_t});
        cfg_write(REG_CLOSE_TICKS, {16'($urandom_range(0, 65535)), close_t});
        cfg_write(REG_UNUSED, $urandom());
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic stim_row_t row(logic a, logic [7:0] sc, logic typed,
                                      logic [2:0] ph, logic [2:0] ev, logic [7:0] kc);
        return stim_row_t'{a, sc, typed, out_item_t'{ph, 1'b0, 1'b0, ev, kc}};
    endfunction

    // result side: check each taken item, random ready, one long hold-off
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (lock_results_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: %p", m_item);
                end else if (m_item.phase !== lock_results_due[0].phase ||
                             m_item.motor_forward !== lock_results_due[0].motor_forward ||
                             m_item.motor_reverse !== lock_results_due[0].motor_reverse ||
                             m_item.event_code !== lock_results_due[0].event_code ||
                             m_item.key_char !== lock_results_due[0].key_char) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result mismatch: expected %p, got %p",
                                 lock_results_due[0], m_item);
                    void'(lock_results_due.pop_front());
                end else begin
                    void'(lock_results_due.pop_front());
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // stimulus
    initial begin
        for (int i = 0; i < CODE_LEN; i++) begin
            lk_entry[i] = '0;
            lk_user[i] = '0;
        end
        // admin entry: tick, unknown codes, admin code star D # 0
        dir_rows[0]  = row(ACT_TICK, 8'h00, 1'b1, PH_ADMIN, EV_NONE, 8'h00);
        dir_rows[1]  = row(ACT_KEY, 8'h00, 1'b1, PH_ADMIN, EV_NONE, 8'h00);
        dir_rows[2]  = row(ACT_KEY, 8'hFF, 1'b1, PH_ADMIN, EV_NONE, 8'h00);
        dir_rows[3]  = row(ACT_KEY, 8'hE7, 1'b1, PH_ADMIN, EV_KEY, 8'h00);
        dir_rows[4]  = row(ACT_KEY, 8'h77, 1'b1, PH_ADMIN, EV_KEY, 8'h44);
        dir_rows[5]  = row(ACT_KEY, 8'hB7, 1'b1, PH_ADMIN, EV_KEY, 8'h23);
        dir_rows[6]  = row(ACT_KEY, 8'hD7, 1'b1, PH_NEWCODE, EV_ADMIN_OK, 8'h30);
        // new user code 1 2 3 C
        dir_rows[7]  = row(ACT_TICK, 8'hFF, 1'b1, PH_NEWCODE, EV_NONE, 8'h00);
        dir_rows[8]  = row(ACT_KEY, 8'hEB, 1'b1, PH_NEWCODE, EV_KEY, 8'h31);
        dir_rows[9]  = row(ACT_KEY, 8'hDB, 1'b1, PH_NEWCODE, EV_KEY, 8'h32);
        dir_rows[10] = row(ACT_KEY, 8'hBB, 1'b1, PH_NEWCODE, EV_KEY, 8'h33);
        dir_rows[11] = row(ACT_KEY, 8'h7B, 1'b1, PH_USER, EV_SET, 8'h43);
        // user entry: tick, unknown code, wrong group, right group
        dir_rows[12] = row(ACT_TICK, 8'h5A, 1'b1, PH_USER, EV_NONE, 8'h00);
        dir_rows[13] = row(ACT_KEY, 8'h12, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[14] = row(ACT_KEY, 8'h7E, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[15] = row(ACT_KEY, 8'hBE, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[16] = row(ACT_KEY, 8'hDE, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[17] = row(ACT_KEY, 8'hEE, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[18] = row(ACT_KEY, 8'hEB, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[19] = row(ACT_KEY, 8'hDB, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[20] = row(ACT_KEY, 8'hBB, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[21] = row(ACT_KEY, 8'h7B, 1'b0, PH_USER, EV_NONE, 8'h00);
        // key ignored while opening, first tick of the open time
        dir_rows[22] = row(ACT_KEY, 8'hED, 1'b0, PH_USER, EV_NONE, 8'h00);
        dir_rows[23] = row(ACT_TICK, 8'hA5, 1'b0, PH_USER, EV_NONE, 8'h00);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // lockout is only reachable from admin entry, which needs a second reset;
        // the run takes the admin-ok path so that user entry and motion are reached
        send_idle_pct = 16;
        recv_idle_pct = 64;
        cfg_write(REG_ADMIN_CODE, 32'h0044_2330);
        cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        for (int i = 0; i < 24; i++)
            send_item(in_item_t'{dir_rows[i].action, dir_rows[i].scan},
                      dir_rows[i].typed, dir_rows[i].want);

        // open and close with the reset tick counts
        run_phase(400, 16, 64);

        set_lock_regs(32'hFFFF_FFFF, 16'd1, 16'd1);
        run_phase(200, 64, 16);

        set_lock_regs(32'h0000_0000, 16'($urandom_range(2, 30)), 16'($urandom_range(2, 30)));
        run_phase(150, 64, 16);

        // zero tick counts end on the first tick; receiver holds off to fill the block
        set_lock_regs($urandom(), 16'd0, 16'd0);
        hold_request = 1'b1;
        run_phase(150, 0, 0);

        set_lock_regs($urandom(), 16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)));
        run_phase(150, 0, 0);

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && lock_results_due.size() == 0)
            $display("keypad_code_lock_controller regression: pass");
        else
            $display("keypad_code_lock_controller regression: fail");
        $finish;
    end

endmodule
